/* rtl/greedy_change_dispenser_assert.svh */
// Assertion macros for the greedy change dispenser.
// Included by gcd_back, the module that checks its own logic; needs no other file.
`ifndef GREEDY_CHANGE_DISPENSER_ASSERT_SVH
`define GREEDY_CHANGE_DISPENSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gcd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gcd assertion failed");
`else
`define GCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/gcd_pkg.sv */
// Shared types, widths and denomination tables of the greedy change dispenser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gcd_pkg;

	localparam int NUM_DENOMS = 5;
	localparam int AMT_W = 16;
	localparam int LOAD_W = 10;
	localparam int OUT_W = 10;
	localparam int STOCK_WIDTH = 10;
	localparam logic [STOCK_WIDTH-1:0] STOCK_RESET = STOCK_WIDTH'(100);

	// Denomination order, largest first.
	localparam int DENOM_TWENTY = 0;
	localparam int DENOM_TEN = 1;
	localparam int DENOM_FIVE = 2;
	localparam int DENOM_ONE = 3;
	localparam int DENOM_HALF = 4;

	localparam int unsigned DENOM_VALUE [NUM_DENOMS] = '{2000, 1000, 500, 100, 50};

	// Quotient by a denomination is (rest * RECIP) >> RECIP_SHIFT with the reciprocal
	// rounded up; the shift exceeds AMT_W plus log2 of the largest denomination,
	// which makes the quotient exact for every 16-bit amount.
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W = 23;
	localparam int PROD_W = AMT_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DENOM_RECIP [NUM_DENOMS] = '{
		RECIP_W'(((1 << RECIP_SHIFT) + DENOM_VALUE[0] - 1) / DENOM_VALUE[0]),
		RECIP_W'(((1 << RECIP_SHIFT) + DENOM_VALUE[1] - 1) / DENOM_VALUE[1]),
		RECIP_W'(((1 << RECIP_SHIFT) + DENOM_VALUE[2] - 1) / DENOM_VALUE[2]),
		RECIP_W'(((1 << RECIP_SHIFT) + DENOM_VALUE[3] - 1) / DENOM_VALUE[3]),
		RECIP_W'(((1 << RECIP_SHIFT) + DENOM_VALUE[4] - 1) / DENOM_VALUE[4])
	};

	// Largest quotient is 65535 / 50 = 1310.
	localparam int FIT_W = 11;
	localparam int CMP_W = (FIT_W > STOCK_WIDTH) ? FIT_W : STOCK_WIDTH;
	// Pieces times denomination; every denomination is below 2**11.
	localparam int PAID_W = STOCK_WIDTH + 11;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_CHANGE = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Classified command as it waits in the queue.
	typedef struct packed {
		logic is_load;
		logic [AMT_W-1:0] rest;
		logic [NUM_DENOMS-1:0][LOAD_W-1:0] load;
	} gcd_item_t;

	// Command as it moves through the denomination stages.
	typedef struct packed {
		logic is_load;
		logic [AMT_W-1:0] rest;
		logic [NUM_DENOMS-1:0][LOAD_W-1:0] load;
		logic [NUM_DENOMS-1:0][STOCK_WIDTH-1:0] take;
	} gcd_work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} gcd_qstat_t;

endpackage

/* rtl/gcd_front.sv */
// Input stage: accepts commands, classifies them and pushes them into the queue.
// Depends on gcd_pkg.
`timescale 1ns / 1ps

module gcd_front import gcd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [AMT_W-1:0]      amount,
	input  logic [LOAD_W-1:0]     load_twenty,
	input  logic [LOAD_W-1:0]     load_ten,
	input  logic [LOAD_W-1:0]     load_five,
	input  logic [LOAD_W-1:0]     load_one,
	input  logic [LOAD_W-1:0]     load_half,
	input  gcd_qstat_t            qstat,
	output logic                  push,
	output gcd_item_t             push_item
);

	logic      valid_s1;
	gcd_item_t item_s1;
	gcd_item_t item_d;
	logic      load_en;

	assign in_stall = valid_s1 && qstat.full;
	assign push = valid_s1 && !qstat.full;
	assign push_item = item_s1;
	assign load_en = !valid_s1 || !qstat.full;

	always_comb begin
		item_d.is_load = (command == CMD_LOAD);
		// A load pays nothing, so its remainder is zero and its result reads all zero.
		item_d.rest = (command == CMD_LOAD) ? '0 : amount;
		item_d.load[DENOM_TWENTY] = load_twenty;
		item_d.load[DENOM_TEN] = load_ten;
		item_d.load[DENOM_FIVE] = load_five;
		item_d.load[DENOM_ONE] = load_one;
		item_d.load[DENOM_HALF] = load_half;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* rtl/gcd_queue.sv */
// Short command queue between the input stage and the denomination pipeline.
// Depends on gcd_pkg.
`timescale 1ns / 1ps

module gcd_queue import gcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  gcd_item_t   push_item,
	input  logic        pop,
	output gcd_item_t   pop_item,
	output gcd_qstat_t  qstat
);

	gcd_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign pop_item = mem_q[rd_ptr_q];
	assign qstat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/gcd_back.sv */
// Denomination pipeline: two stages per denomination, each owning its stock counter,
// with the last stage acting as the output register. Depends on gcd_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "greedy_change_dispenser_assert.svh"

module gcd_back import gcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  gcd_item_t         pop_item,
	input  gcd_qstat_t        qstat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OUT_W-1:0]  out_twenty,
	output logic [OUT_W-1:0]  out_ten,
	output logic [OUT_W-1:0]  out_five,
	output logic [OUT_W-1:0]  out_one,
	output logic [OUT_W-1:0]  out_half,
	output logic [AMT_W-1:0]  leftover,
	output logic              shortfall
);

	gcd_work_t                                stage_in [NUM_DENOMS];
	logic [NUM_DENOMS-1:0]                    stage_in_v;
	logic [PROD_W-1:0]                        prod_a [NUM_DENOMS];
	logic [FIT_W-1:0]                         fit_a [NUM_DENOMS];
	gcd_work_t                                a_s1 [NUM_DENOMS];
	logic [FIT_W-1:0]                         fit_s1 [NUM_DENOMS];
	logic [NUM_DENOMS-1:0]                    va_s1;
	logic [NUM_DENOMS-1:0][STOCK_WIDTH-1:0]   take_b;
	logic [PAID_W-1:0]                        paid_b [NUM_DENOMS];
	gcd_work_t                                b_next [NUM_DENOMS];
	gcd_work_t                                b_s2 [NUM_DENOMS];
	logic [NUM_DENOMS-1:0]                    vb_s2;
	logic [NUM_DENOMS-1:0][STOCK_WIDTH-1:0]   stock_q;
	logic                                     move;
	gcd_work_t                                last;

	// The whole pipeline advances together unless a finished result is held.
	assign move = !(vb_s2[NUM_DENOMS-1] && out_stall);
	assign pop = move && !qstat.empty;

	always_comb begin
		stage_in[0].is_load = pop_item.is_load;
		stage_in[0].rest = pop_item.rest;
		stage_in[0].load = pop_item.load;
		stage_in[0].take = '0;
		stage_in_v[0] = !qstat.empty;
		for (int k = 1; k < NUM_DENOMS; k++) begin
			stage_in[k] = b_s2[k-1];
			stage_in_v[k] = vb_s2[k-1];
		end
	end

	// First stage of each denomination: how many pieces the remaining amount holds.
	always_comb begin
		for (int k = 0; k < NUM_DENOMS; k++) begin
			prod_a[k] = PROD_W'(stage_in[k].rest) * PROD_W'(DENOM_RECIP[k]);
			fit_a[k] = prod_a[k][RECIP_SHIFT +: FIT_W];
		end
	end

	// Second stage: limit by stock, update the stock and the remaining amount.
	always_comb begin
		for (int k = 0; k < NUM_DENOMS; k++) begin
			take_b[k] = (CMP_W'(fit_s1[k]) < CMP_W'(stock_q[k])) ?
				STOCK_WIDTH'(fit_s1[k]) : stock_q[k];
			paid_b[k] = PAID_W'(take_b[k]) * PAID_W'(DENOM_VALUE[k]);
			b_next[k] = a_s1[k];
			if (!a_s1[k].is_load) begin
				b_next[k].take[k] = take_b[k];
				b_next[k].rest = a_s1[k].rest - AMT_W'(paid_b[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1 <= '0;
			vb_s2 <= '0;
			for (int k = 0; k < NUM_DENOMS; k++) begin
				stock_q[k] <= STOCK_RESET;
			end
		end else if (move) begin
			va_s1 <= stage_in_v;
			vb_s2 <= va_s1;
			for (int k = 0; k < NUM_DENOMS; k++) begin
				if (va_s1[k]) begin
					if (a_s1[k].is_load) begin
						stock_q[k] <= STOCK_WIDTH'(a_s1[k].load[k]);
					end else begin
						stock_q[k] <= stock_q[k] - take_b[k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			for (int k = 0; k < NUM_DENOMS; k++) begin
				a_s1[k] <= stage_in[k];
				fit_s1[k] <= fit_a[k];
				b_s2[k] <= b_next[k];
			end
		end
	end

	assign last = b_s2[NUM_DENOMS-1];
	assign out_valid = vb_s2[NUM_DENOMS-1];
	assign out_twenty = OUT_W'(last.take[DENOM_TWENTY]);
	assign out_ten = OUT_W'(last.take[DENOM_TEN]);
	assign out_five = OUT_W'(last.take[DENOM_FIVE]);
	assign out_one = OUT_W'(last.take[DENOM_ONE]);
	assign out_half = OUT_W'(last.take[DENOM_HALF]);
	assign leftover = last.rest;
	assign shortfall = (last.rest != '0);

	// A change command never adds to a stock.
	for (genvar k = 0; k < NUM_DENOMS; k++) begin : g_stock_chk
		`GCD_ASSERT_NEXT(a_stock_no_grow, clk, arst_n, move && va_s1[k] && !a_s1[k].is_load, stock_q[k] <= $past(stock_q[k]))
	end

	// After the smallest denomination, what is left is below it or its stock ran out.
	`GCD_ASSERT_NEXT(a_greedy_done, clk, arst_n, move && va_s1[NUM_DENOMS-1] && !a_s1[NUM_DENOMS-1].is_load, (b_s2[NUM_DENOMS-1].rest < AMT_W'(DENOM_VALUE[NUM_DENOMS-1])) || (stock_q[NUM_DENOMS-1] == '0))

	// A held result freezes every stock.
	`GCD_ASSERT_NEXT(a_stall_freeze, clk, arst_n, out_valid && out_stall, $stable(stock_q))

endmodule

/* rtl/greedy_change_dispenser.sv */
// Greedy change dispenser with five limited denomination stocks.
// Input channel in_valid / in_stall carries command, amount and the five load values;
// a transfer happens at a clock edge with valid high and stall low. Command 0 pays
// out amount largest denomination first (2000, 1000, 500, 100, 50), each count the
// smaller of what fits and what is in stock; command 1 overwrites all five stocks.
// Output channel out_valid / out_stall returns one result per command: the pieces
// of each denomination, the leftover and the shortfall flag (all zero for a load).
// A command passes through an input register, the queue, then two stages per
// denomination. Throughput is one command per cycle while the receiver does not
// stall, set by the stage that updates each stock counter once a cycle. When the
// receiver stalls, the denomination pipeline holds with its stocks;
// the four-entry queue and the input register keep taking commands until full,
// and then in_stall rises. Reset empties the queue and pipeline and sets every
// stock to 100.
// Depends on gcd_pkg, gcd_front, gcd_queue and gcd_back.
`timescale 1ns / 1ps

module greedy_change_dispenser import gcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [AMT_W-1:0]  amount,
	input  logic [LOAD_W-1:0] load_twenty,
	input  logic [LOAD_W-1:0] load_ten,
	input  logic [LOAD_W-1:0] load_five,
	input  logic [LOAD_W-1:0] load_one,
	input  logic [LOAD_W-1:0] load_half,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OUT_W-1:0]  out_twenty,
	output logic [OUT_W-1:0]  out_ten,
	output logic [OUT_W-1:0]  out_five,
	output logic [OUT_W-1:0]  out_one,
	output logic [OUT_W-1:0]  out_half,
	output logic [AMT_W-1:0]  leftover,
	output logic              shortfall
);

	gcd_qstat_t qstat;
	logic       push;
	gcd_item_t  push_item;
	logic       pop;
	gcd_item_t  pop_item;

	gcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.amount      (amount),
		.load_twenty (load_twenty),
		.load_ten    (load_ten),
		.load_five   (load_five),
		.load_one    (load_one),
		.load_half   (load_half),
		.qstat       (qstat),
		.push        (push),
		.push_item   (push_item)
	);

	gcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	gcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_item   (pop_item),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_twenty (out_twenty),
		.out_ten    (out_ten),
		.out_five   (out_five),
		.out_one    (out_one),
		.out_half   (out_half),
		.leftover   (leftover),
		.shortfall  (shortfall)
	);

endmodule

/* sim/testbench.sv */
// Self-checking testbench for greedy_change_dispenser: directed and random change and
// restock commands, with a payout predictor and scoreboard inside. Depends on gcd_pkg and greedy_change_dispenser.
`timescale 1ns / 1ps

module testbench;
	import gcd_pkg::*;

	localparam int unsigned PIASTERS [NUM_DENOMS] = '{2000, 1000, 500, 100, 50};
	localparam int RESET_STOCK = 100;
	localparam int RANDOM_ITEMS = 600;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_PRINTED = 30;

	typedef struct packed {
		logic [NUM_DENOMS-1:0][OUT_W-1:0] pieces;
		logic [AMT_W-1:0] leftover;
		logic shortfall;
	} payout_t;

	class change_book;
		logic [STOCK_WIDTH-1:0] stock [NUM_DENOMS];
		payout_t owed_payouts[$];
		int mismatches;
		string piece_name [NUM_DENOMS];

		function new();
			mismatches = 0;
			piece_name = '{"out_twenty", "out_ten", "out_five", "out_one", "out_half"};
			foreach (stock[k])
				stock[k] = STOCK_WIDTH'(RESET_STOCK);
		endfunction

		task report(input string what);
			if (mismatches < MAX_PRINTED)
				$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// Works out the payout of one accepted command and updates the stocks.
		function void record_command(input logic cmd, input logic [AMT_W-1:0] amt,
				input logic [NUM_DENOMS-1:0][LOAD_W-1:0] loads);
			payout_t due;
			int unsigned rest;
			int unsigned fit;
			int unsigned take;
			due = '0;
			if (cmd == CMD_LOAD) begin
				for (int k = 0; k < NUM_DENOMS; k++)
					stock[k] = STOCK_WIDTH'(loads[k]);
			end else begin
				rest = amt;
				for (int k = 0; k < NUM_DENOMS; k++) begin
					fit = rest / PIASTERS[k];
					take = (fit < stock[k]) ? fit : stock[k];
					due.pieces[k] = OUT_W'(take);
					stock[k] = stock[k] - STOCK_WIDTH'(take);
					rest = rest - take * PIASTERS[k];
				end
				due.leftover = AMT_W'(rest);
				due.shortfall = (rest != 0);
			end
			owed_payouts.push_back(due);
		endfunction

		task match_payout(input payout_t seen);
			payout_t due;
			if (owed_payouts.size() == 0) begin
				report("result with no command outstanding");
			end else begin
				due = owed_payouts.pop_front();
				for (int k = 0; k < NUM_DENOMS; k++)
					if (seen.pieces[k] !== due.pieces[k])
						report($sformatf("%s got %0d expected %0d", piece_name[k],
							seen.pieces[k], due.pieces[k]));
				if (seen.leftover !== due.leftover)
					report($sformatf("leftover got %0d expected %0d",
						seen.leftover, due.leftover));
				if (seen.shortfall !== due.shortfall)
					report($sformatf("shortfall got %0b expected %0b",
						seen.shortfall, due.shortfall));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [AMT_W-1:0] amount;
	logic [LOAD_W-1:0] load_twenty;
	logic [LOAD_W-1:0] load_ten;
	logic [LOAD_W-1:0] load_five;
	logic [LOAD_W-1:0] load_one;
	logic [LOAD_W-1:0] load_half;
	logic out_valid;
	logic out_stall;
	logic [OUT_W-1:0] out_twenty;
	logic [OUT_W-1:0] out_ten;
	logic [OUT_W-1:0] out_five;
	logic [OUT_W-1:0] out_one;
	logic [OUT_W-1:0] out_half;
	logic [AMT_W-1:0] leftover;
	logic shortfall;

	change_book book;
	int sent_items = 0;

	greedy_change_dispenser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.amount(amount),
		.load_twenty(load_twenty),
		.load_ten(load_ten),
		.load_five(load_five),
		.load_one(load_one),
		.load_half(load_half),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_twenty(out_twenty),
		.out_ten(out_ten),
		.out_five(out_five),
		.out_one(out_one),
		.out_half(out_half),
		.leftover(leftover),
		.shortfall(shortfall)
	);

	always #10 clk = ~clk;

	// Called just after a rising edge; returns just after the edge of the transfer.
	task automatic drive_item(input logic cmd, input logic [AMT_W-1:0] amt,
			input logic [NUM_DENOMS-1:0][LOAD_W-1:0] loads);
		in_valid <= 1'b1;
		command <= cmd;
		amount <= amt;
		load_twenty <= loads[DENOM_TWENTY];
		load_ten <= loads[DENOM_TEN];
		load_five <= loads[DENOM_FIVE];
		load_one <= loads[DENOM_ONE];
		load_half <= loads[DENOM_HALF];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.record_command(cmd, amt, loads);
		sent_items++;
	endtask

	// The load fields carry junk on a change command; the block must ignore them.
	task automatic pay(input logic [AMT_W-1:0] amt);
		logic [NUM_DENOMS-1:0][LOAD_W-1:0] junk;
		for (int k = 0; k < NUM_DENOMS; k++)
			junk[k] = LOAD_W'($urandom);
		drive_item(CMD_CHANGE, amt, junk);
	endtask

	task automatic restock(input int twenty, input int ten, input int five, input int one,
			input int half);
		logic [NUM_DENOMS-1:0][LOAD_W-1:0] loads;
		loads[DENOM_TWENTY] = LOAD_W'(twenty);
		loads[DENOM_TEN] = LOAD_W'(ten);
		loads[DENOM_FIVE] = LOAD_W'(five);
		loads[DENOM_ONE] = LOAD_W'(one);
		loads[DENOM_HALF] = LOAD_W'(half);
		drive_item(CMD_LOAD, AMT_W'($urandom), loads);
	endtask

	always @(posedge clk) begin : watch
		payout_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.pieces[DENOM_TWENTY] = out_twenty;
			seen.pieces[DENOM_TEN] = out_ten;
			seen.pieces[DENOM_FIVE] = out_five;
			seen.pieces[DENOM_ONE] = out_one;
			seen.pieces[DENOM_HALF] = out_half;
			seen.leftover = leftover;
			seen.shortfall = shortfall;
			book.match_payout(seen);
		end
	end

	// Receiver: runs of random stall patterns, plus one long hold that backs up the block.
	initial begin : receiver
		bit held_off;
		int span;
		int mode;
		held_off = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && sent_items >= HOLD_AFTER) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				held_off = 1'b1;
			end
			span = $urandom_range(1, 40);
			mode = $urandom_range(0, 3);
			repeat (span) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					2: out_stall <= 1'b1;
					default: out_stall <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : sender
		logic [NUM_DENOMS-1:0][LOAD_W-1:0] loads;
		logic [AMT_W-1:0] amt;
		int burst_left;
		int gap;
		book = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_CHANGE;
		amount <= '0;
		load_twenty <= '0;
		load_ten <= '0;
		load_five <= '0;
		load_one <= '0;
		load_half <= '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset stocks of 100 each.
		pay(0);
		pay(3850);
		pay(49);
		pay(125);
		pay(16'hFFFF);
		restock(0, 0, 0, 0, 0);
		pay(50);
		restock(1023, 1023, 1023, 1023, 1023);
		pay(16'hFFFF);
		restock(0, 0, 0, 0, 1023);
		pay(16'hFFFF);
		restock(0, 0, 0, 1023, 0);
		pay(16'hFFFF);
		restock(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
		pay(16'hAAAA);
		pay(16'h5555);
		restock(1, 1, 1, 1, 1);
		pay(3650);
		pay(3650);
		// Stock runs out partway, and the smaller pieces cannot make up the rest.
		restock(2, 0, 3, 0, 0);
		pay(6000);
		restock(RESET_STOCK, RESET_STOCK, RESET_STOCK, RESET_STOCK, RESET_STOCK);

		burst_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap)
						@(posedge clk);
				end
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
			if ($urandom_range(0, 6) == 0) begin
				for (int k = 0; k < NUM_DENOMS; k++)
					case ($urandom_range(0, 2))
						0: loads[k] = LOAD_W'($urandom_range(0, 5));
						1: loads[k] = LOAD_W'($urandom_range(0, 1023));
						default: loads[k] = LOAD_W'($urandom_range(90, 110));
					endcase
				drive_item(CMD_LOAD, AMT_W'($urandom), loads);
			end else begin
				case ($urandom_range(0, 3))
					0, 1: amt = AMT_W'($urandom_range(0, 1310) * 50);
					2: amt = AMT_W'($urandom_range(0, 65535));
					default: amt = AMT_W'($urandom_range(0, 5000));
				endcase
				pay(amt);
			end
		end
		in_valid <= 1'b0;

		while (book.owed_payouts.size() != 0)
			@(posedge clk);
		// Let any stray transfer show up before the verdict.
		repeat (30)
			@(posedge clk);
		if (book.mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

/* greedy_change_dispenser.f */
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_front.sv
rtl/gcd_queue.sv
rtl/gcd_back.sv
rtl/greedy_change_dispenser.sv
sim/testbench.sv
